// File: rtl/ngfr_pkg.sv
// Shared constants and types for the n-gram frequency ranker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ngfr_pkg;
  localparam int COUNT_BITS  = 16;
  localparam int TOP_PAIRS   = 10;
  localparam int TOP_TRIPLES = 5;

  localparam int ALPHA  = 26;
  localparam int ALPHA2 = ALPHA * ALPHA;
  localparam int ALPHA3 = ALPHA * ALPHA * ALPHA;

  localparam int SADDR_W = $clog2(ALPHA);
  localparam int PADDR_W = $clog2(ALPHA2);
  localparam int TADDR_W = $clog2(ALPHA3);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_SINGLE = 2'd0;
  localparam kind_t KIND_PAIR   = 2'd1;
  localparam kind_t KIND_TRIPLE = 2'd2;
endpackage
`default_nettype wire

// File: rtl/ngram_frequency_ranker.sv
// N-gram frequency ranker top level: counting stores and ranking sequencer.
// Depends on ngfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Input channel (in_valid/in_stall, in_letter, in_final_letter): one letter
//  per item. Each letter does a read-modify-write of its single, pair and
//  triple counters (saturating), the latter two once enough letters precede it;
//  in_stall is high until the counter port is free. Codes 26..31 are not counted.
//  On an item with in_final_letter set, the block emits a report on the
//  result channel (out_valid/out_stall): 26 letter ranks, TOP_PAIRS pair
//  ranks, TOP_TRIPLES triple ranks, the last one flagged by
//  out_end_of_report. Each rank is one pass of a single compare unit over
//  the store (one entry per cycle, registered memory read), so a pick lasts
//  one full scan plus the time the result waits on out_stall. A stalled result
//  holds; the sequencer waits on it before the next pick.
//  After the report, and after reset, a clearing sweep zeroes all stores,
//  one triple entry per cycle, with in_stall high.
//  rst_n is synchronous, active low.
module ngram_frequency_ranker
  import ngfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] in_letter,
  input  wire logic       in_final_letter,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [4:0]      out_rank,
  output logic [4:0]      out_first_index,
  output logic [4:0]      out_second_index,
  output logic [4:0]      out_third_index,
  output logic            out_end_of_report
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_PICK, ST_SCAN,
    ST_DRAIN, ST_ZERO, ST_EMIT, ST_CLEAR
  } state_t;

  // Count stores
  count_t mem_s [ALPHA];
  count_t mem_p [ALPHA2];
  count_t mem_t [ALPHA3];
  count_t rd_s_r, rd_p_r, rd_t_r;

  state_t state_r;
  kind_t  kind_r;
  logic [4:0] rank_r;
  logic [1:0] seen_r;
  logic [4:0] prev_l_r, prev2_l_r;
  logic       final_r, do_p_r, do_t_r;
  logic [SADDR_W-1:0] s_addr_r;
  logic [PADDR_W-1:0] p_addr_r;
  logic [TADDR_W-1:0] t_addr_r;

  // Scan odometer (c lowest digit), linear index, and one-stage delayed copy
  logic [TADDR_W-1:0] lin_r, p_lin_r, best_lin_r, prv_lin_r;
  logic [4:0] sa_r, sb_r, sc_r, p_a_r, p_b_r, p_c_r;
  logic [4:0] best_a_r, best_b_r, best_c_r, prv_a_r, prv_b_r, prv_c_r;
  logic       p_vld_r;
  count_t     best_val_r;

  logic       out_valid_r, out_eor_r;
  logic [1:0] out_kind_r;
  logic [4:0] out_rank_r, out_a_r, out_b_r, out_c_r;

  logic               we_s, we_p, we_t;
  logic [SADDR_W-1:0] wa_s;
  logic [PADDR_W-1:0] wa_p;
  logic [TADDR_W-1:0] wa_t;
  count_t             wd_s, wd_p, wd_t;
  logic               re_s, re_p, re_t;
  logic [SADDR_W-1:0] ra_s;
  logic [PADDR_W-1:0] ra_p;
  logic [TADDR_W-1:0] ra_t;
  count_t             rd_sel;
  logic [TADDR_W-1:0] last_lin;
  logic [4:0]         last_rank;
  logic               in_acc;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == '1) ? v : v + count_t'(1);
  endfunction

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    case (kind_r)
      KIND_SINGLE: begin
        rd_sel    = rd_s_r;
        last_lin  = TADDR_W'(ALPHA - 1);
        last_rank = 5'(ALPHA - 1);
      end
      KIND_PAIR: begin
        rd_sel    = rd_p_r;
        last_lin  = TADDR_W'(ALPHA2 - 1);
        last_rank = 5'(TOP_PAIRS - 1);
      end
      default: begin
        rd_sel    = rd_t_r;
        last_lin  = TADDR_W'(ALPHA3 - 1);
        last_rank = 5'(TOP_TRIPLES - 1);
      end
    endcase
  end

  // Memory port control
  always_comb begin
    we_s = 1'b0; we_p = 1'b0; we_t = 1'b0;
    wa_s = s_addr_r; wa_p = p_addr_r; wa_t = t_addr_r;
    wd_s = '0; wd_p = '0; wd_t = '0;
    re_s = 1'b0; re_p = 1'b0; re_t = 1'b0;
    ra_s = s_addr_r; ra_p = p_addr_r; ra_t = t_addr_r;
    case (state_r)
      ST_CNT_RD: begin
        re_s = 1'b1; re_p = 1'b1; re_t = 1'b1;
      end
      ST_CNT_WR: begin
        we_s = 1'b1;     wd_s = sat_inc(rd_s_r);
        we_p = do_p_r;   wd_p = sat_inc(rd_p_r);
        we_t = do_t_r;   wd_t = sat_inc(rd_t_r);
      end
      ST_SCAN: begin
        re_s = (kind_r == KIND_SINGLE);
        re_p = (kind_r == KIND_PAIR);
        re_t = (kind_r == KIND_TRIPLE);
        ra_s = lin_r[SADDR_W-1:0];
        ra_p = lin_r[PADDR_W-1:0];
        ra_t = lin_r;
      end
      ST_ZERO: begin
        we_s = (kind_r == KIND_SINGLE);
        we_p = (kind_r == KIND_PAIR);
        we_t = (kind_r == KIND_TRIPLE);
        wa_s = best_lin_r[SADDR_W-1:0];
        wa_p = best_lin_r[PADDR_W-1:0];
        wa_t = best_lin_r;
      end
      ST_CLEAR: begin
        we_t = 1'b1;
        we_p = (lin_r < TADDR_W'(ALPHA2));
        we_s = (lin_r < TADDR_W'(ALPHA));
        wa_s = lin_r[SADDR_W-1:0];
        wa_p = lin_r[PADDR_W-1:0];
        wa_t = lin_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_s) mem_s[wa_s] <= wd_s;
    if (re_s) rd_s_r <= mem_s[ra_s];
  end

  always_ff @(posedge clk) begin
    if (we_p) mem_p[wa_p] <= wd_p;
    if (re_p) rd_p_r <= mem_p[ra_p];
  end

  always_ff @(posedge clk) begin
    if (we_t) mem_t[wa_t] <= wd_t;
    if (re_t) rd_t_r <= mem_t[ra_t];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lin_r       <= '0;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      seen_r      <= '0;
      prev_l_r    <= '0;
      prev2_l_r   <= '0;
      kind_r      <= KIND_SINGLE;
      rank_r      <= '0;
      final_r     <= 1'b0;
    end else begin
      // shared compare unit: first maximum wins (strict greater)
      if (p_vld_r && (rd_sel > best_val_r)) begin
        best_val_r <= rd_sel;
        best_lin_r <= p_lin_r;
        best_a_r   <= p_a_r;
        best_b_r   <= p_b_r;
        best_c_r   <= p_c_r;
      end
      // read data of a scan slot arrives in the next cycle
      p_vld_r <= (state_r == ST_SCAN);

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            final_r <= in_final_letter;
            kind_r  <= KIND_SINGLE;
            rank_r  <= '0;
            prv_lin_r <= '0;
            prv_a_r <= '0; prv_b_r <= '0; prv_c_r <= '0;
            if (in_letter < 5'(ALPHA)) begin
              s_addr_r  <= in_letter[SADDR_W-1:0];
              p_addr_r  <= PADDR_W'(prev_l_r) * PADDR_W'(ALPHA) + PADDR_W'(in_letter);
              t_addr_r  <= TADDR_W'(prev2_l_r) * TADDR_W'(ALPHA2)
                         + TADDR_W'(prev_l_r) * TADDR_W'(ALPHA) + TADDR_W'(in_letter);
              do_p_r    <= (seen_r != 2'd0);
              do_t_r    <= (seen_r == 2'd2);
              prev2_l_r <= prev_l_r;
              prev_l_r  <= in_letter;
              if (seen_r != 2'd2) seen_r <= seen_r + 2'd1;
              state_r   <= ST_CNT_RD;
            end else if (in_final_letter) begin
              state_r <= ST_PICK;
            end
          end
        end
        ST_CNT_RD: state_r <= ST_CNT_WR;
        ST_CNT_WR: state_r <= final_r ? ST_PICK : ST_IDLE;
        ST_PICK: begin
          best_val_r <= '0;
          best_lin_r <= prv_lin_r;
          best_a_r   <= prv_a_r;
          best_b_r   <= prv_b_r;
          best_c_r   <= prv_c_r;
          lin_r <= '0;
          sa_r <= '0; sb_r <= '0; sc_r <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          p_lin_r <= lin_r;
          p_a_r <= sa_r; p_b_r <= sb_r; p_c_r <= sc_r;
          lin_r <= lin_r + TADDR_W'(1);
          if (sc_r == 5'(ALPHA - 1)) begin
            sc_r <= '0;
            if (sb_r == 5'(ALPHA - 1)) begin
              sb_r <= '0;
              sa_r <= sa_r + 5'd1;
            end else begin
              sb_r <= sb_r + 5'd1;
            end
          end else begin
            sc_r <= sc_r + 5'd1;
          end
          if (lin_r == last_lin) state_r <= ST_DRAIN;
        end
        ST_DRAIN: state_r <= ST_ZERO;
        ST_ZERO: begin
          // exhausted letters fall to index 0; pairs and triples repeat
          if (kind_r != KIND_SINGLE) begin
            prv_lin_r <= best_lin_r;
            prv_a_r <= best_a_r; prv_b_r <= best_b_r; prv_c_r <= best_c_r;
          end
          out_valid_r <= 1'b1;
          out_kind_r  <= kind_r;
          out_rank_r  <= rank_r;
          out_eor_r   <= (kind_r == KIND_TRIPLE) && (rank_r == last_rank);
          case (kind_r)
            KIND_SINGLE: begin
              out_a_r <= best_c_r; out_b_r <= '0; out_c_r <= '0;
            end
            KIND_PAIR: begin
              out_a_r <= best_b_r; out_b_r <= best_c_r; out_c_r <= '0;
            end
            default: begin
              out_a_r <= best_a_r; out_b_r <= best_b_r; out_c_r <= best_c_r;
            end
          endcase
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (rank_r == last_rank) begin
              rank_r    <= '0;
              prv_lin_r <= '0;
              prv_a_r <= '0; prv_b_r <= '0; prv_c_r <= '0;
              case (kind_r)
                KIND_SINGLE: begin
                  kind_r <= KIND_PAIR; state_r <= ST_PICK;
                end
                KIND_PAIR: begin
                  kind_r <= KIND_TRIPLE; state_r <= ST_PICK;
                end
                default: begin
                  lin_r <= '0; state_r <= ST_CLEAR;
                end
              endcase
            end else begin
              rank_r  <= rank_r + 5'd1;
              state_r <= ST_PICK;
            end
          end
        end
        ST_CLEAR: begin
          lin_r <= lin_r + TADDR_W'(1);
          if (lin_r == TADDR_W'(ALPHA3 - 1)) begin
            seen_r    <= '0;
            prev_l_r  <= '0;
            prev2_l_r <= '0;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_rank          = out_rank_r;
  assign out_first_index   = out_a_r;
  assign out_second_index  = out_b_r;
  assign out_third_index   = out_c_r;
  assign out_end_of_report = out_eor_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while a report item is pending");
  a_eor_triple: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_report) |-> (out_kind == KIND_TRIPLE))
    else $error("end of report on a non-triple item");
  a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_report && !out_stall) |=> (state_r == ST_CLEAR))
    else $error("no clearing sweep after report");
`endif

endmodule
`default_nettype wire
